@@ hdl/cdte_pkg.sv @@
// Shared types, constants and lookup functions for the civil date/time to epoch converter.
package cdte_pkg;

	// Meridiem marker codes
	localparam logic [1:0] MER_NONE = 2'd0;
	localparam logic [1:0] MER_AM   = 2'd1;
	localparam logic [1:0] MER_PM   = 2'd2;

	// Highest meaningful fraction digit count (nanoseconds)
	localparam logic [3:0] MAX_DIGITS = 4'd9;

	// Year bias: a multiple of 400 that makes every adjusted year non-negative
	localparam logic [16:0] YEAR_BIAS = 17'd32800;
	// floor(yb / 100) == (yb * RECIP_100) >> 24 for every biased year
	localparam logic [17:0] RECIP_100 = 18'd167773;
	// Bias terms removed after the biased divisions
	localparam logic signed [26:0] CENT_BIAS = 27'sd328;
	localparam logic signed [26:0] QUAD_BIAS = 27'sd82;
	// Days from 0000-03-01 to 1970-01-01
	localparam logic signed [26:0] EPOCH_SHIFT = 27'sd719468;
	localparam logic signed [26:0] DAYS_PER_YEAR = 27'sd365;
	localparam logic signed [47:0] SECS_PER_DAY = 48'sd86400;
	localparam logic signed [23:0] HALF_DAY_SECS = 24'sd43200;

	// Hand-off between the date front end and the scaling back end
	typedef struct packed {
		logic signed [26:0] days;   // days since epoch
		logic signed [23:0] secs;   // time of day minus zone offset, in seconds
		logic [29:0]        nanos;  // raw nanoseconds
		logic [30:0]        nq_est; // truncated nanos estimate, low by at most one
	} cdte_mid_t;

	// Days from March 1st to the first of a month, March-based year
	function automatic logic [8:0] month_base(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd0:  r = 9'd275;
			4'd1:  r = 9'd306;
			4'd2:  r = 9'd337;
			4'd3:  r = 9'd0;
			4'd4:  r = 9'd31;
			4'd5:  r = 9'd61;
			4'd6:  r = 9'd92;
			4'd7:  r = 9'd122;
			4'd8:  r = 9'd153;
			4'd9:  r = 9'd184;
			4'd10: r = 9'd214;
			4'd11: r = 9'd245;
			4'd12: r = 9'd275;
			4'd13: r = 9'd306;
			4'd14: r = 9'd337;
			4'd15: r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Clamp the digit register to nanoseconds
	function automatic logic [3:0] sat_digits(input logic [3:0] fd);
		return (fd > MAX_DIGITS) ? MAX_DIGITS : fd;
	endfunction

	// Units per second: 10^dig
	function automatic logic [29:0] unit_scale(input logic [3:0] dig);
		logic [29:0] r;
		case (dig)
			4'd0: r = 30'd1;
			4'd1: r = 30'd10;
			4'd2: r = 30'd100;
			4'd3: r = 30'd1000;
			4'd4: r = 30'd10000;
			4'd5: r = 30'd100000;
			4'd6: r = 30'd1000000;
			4'd7: r = 30'd10000000;
			4'd8: r = 30'd100000000;
			4'd9: r = 30'd1000000000;
			default: r = 30'd1000000000;
		endcase
		return r;
	endfunction

	// Nanoseconds per unit: 10^(9-dig)
	function automatic logic [29:0] nano_div(input logic [3:0] dig);
		logic [29:0] r;
		case (dig)
			4'd0: r = 30'd1000000000;
			4'd1: r = 30'd100000000;
			4'd2: r = 30'd10000000;
			4'd3: r = 30'd1000000;
			4'd4: r = 30'd100000;
			4'd5: r = 30'd10000;
			4'd6: r = 30'd1000;
			4'd7: r = 30'd100;
			4'd8: r = 30'd10;
			4'd9: r = 30'd1;
			default: r = 30'd1;
		endcase
		return r;
	endfunction

	// floor(2^32 / nano_div(dig))
	function automatic logic [32:0] nano_recip(input logic [3:0] dig);
		logic [32:0] r;
		case (dig)
			4'd0: r = 33'd4;
			4'd1: r = 33'd42;
			4'd2: r = 33'd429;
			4'd3: r = 33'd4294;
			4'd4: r = 33'd42949;
			4'd5: r = 33'd429496;
			4'd6: r = 33'd4294967;
			4'd7: r = 33'd42949672;
			4'd8: r = 33'd429496729;
			4'd9: r = 33'd4294967296;
			default: r = 33'd4294967296;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/cdte_front.sv @@
// Front end: day count from the civil date, seconds of day, nanos quotient estimate.
module cdte_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [15:0]      year,
	input  logic [3:0]              month,
	input  logic [4:0]              day,
	input  logic [4:0]              hour,
	input  logic [5:0]              minute,
	input  logic [5:0]              second,
	input  logic [29:0]             nanos,
	input  logic signed [19:0]      tz_offset,
	input  logic [1:0]              meridiem,
	input  logic [3:0]              dig,
	output logic                    out_valid,
	input  logic                    out_ready,
	output cdte_pkg::cdte_mid_t     out_data
);
	import cdte_pkg::*;

	logic en_s1, en_s2;
	logic v_s1, v_s2;

	// Stage 1 combinational terms
	logic              early;
	logic signed [16:0] y_adj_c;
	logic [16:0]       yb_c;
	logic [34:0]       yprod_c;
	logic signed [9:0] doy_c;
	logic signed [23:0] tod_c;
	logic signed [23:0] tz_ext;
	logic signed [23:0] secs_c;
	logic [62:0]       nprod_c;

	// Stage 1 registers
	logic signed [16:0] y_adj_s1;
	logic [10:0]       q100_s1;
	logic signed [9:0] doy_s1;
	logic signed [23:0] secs_s1;
	logic [29:0]       nanos_s1;
	logic [30:0]       nq_s1;

	// Stage 2 terms
	logic signed [26:0] y27;
	logic signed [26:0] days_c;
	cdte_mid_t         mid_s2;

	// Advance a stage when it is empty or the next one advances
	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// Shift the March-based year back for month zero, January and February
	assign early   = (month == 4'd0) || (month == 4'd1) || (month == 4'd2);
	assign y_adj_c = $signed({year[15], year}) - $signed({16'd0, early});
	assign yb_c    = 17'(y_adj_c) + YEAR_BIAS;
	assign yprod_c = yb_c * RECIP_100;

	// Day of the March-based year
	assign doy_c = $signed({1'b0, month_base(month)}) + $signed({5'd0, day}) - 10'sd1;

	// Seconds of day with meridiem fix and zone offset removed
	assign tod_c  = $signed(24'(hour) * 24'd3600 + 24'(minute) * 24'd60 + 24'(second));
	assign tz_ext = {{4{tz_offset[19]}}, tz_offset};
	always_comb begin
		secs_c = tod_c - tz_ext;
		if (meridiem == MER_PM && hour != 5'd12) begin
			secs_c = secs_c + HALF_DAY_SECS;
		end else if (meridiem == MER_AM && hour == 5'd12) begin
			secs_c = secs_c - HALF_DAY_SECS;
		end
	end

	// Reciprocal estimate of nanos / 10^(9-dig)
	assign nprod_c = nanos * nano_recip(dig);

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (en_s1) begin
			y_adj_s1 <= y_adj_c;
			q100_s1  <= yprod_c[34:24];
			doy_s1   <= doy_c;
			secs_s1  <= secs_c;
			nanos_s1 <= nanos;
			nq_s1    <= nprod_c[62:32];
		end
	end

	// Era-free day count: 365y + y/4 - y/100 + y/400 + doy - epoch
	assign y27    = {{10{y_adj_s1[16]}}, y_adj_s1};
	assign days_c = y27 * DAYS_PER_YEAR + (y27 >>> 2)
		- $signed({16'd0, q100_s1}) + CENT_BIAS
		+ $signed({18'd0, q100_s1[10:2]}) - QUAD_BIAS
		+ $signed({{17{doy_s1[9]}}, doy_s1}) - EPOCH_SHIFT;

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (en_s2) begin
			mid_s2.days   <= days_c;
			mid_s2.secs   <= secs_s1;
			mid_s2.nanos  <= nanos_s1;
			mid_s2.nq_est <= nq_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = mid_s2;

endmodule

@@ hdl/cdte_back.sv @@
// Back end: seconds since epoch, scaling to the chosen unit, nanos fraction added.
module cdte_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cdte_pkg::cdte_mid_t  in_data,
	input  logic [3:0]           dig,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [63:0]   timestamp
);
	import cdte_pkg::*;

	logic en_s3, en_s4, en_s5;
	logic v_s3, v_s4, v_s5;

	logic signed [47:0] days48;
	logic signed [47:0] secs48;
	logic signed [47:0] t_c;
	logic [29:0]        ndiv;
	logic [60:0]        qd_c;
	logic [30:0]        rem_c;

	logic signed [47:0] t_s3;
	logic [30:0]        rem_s3;
	logic [30:0]        nq_s3;

	logic [29:0]        scale;
	logic signed [63:0] plo_c;
	logic signed [63:0] phi_c;
	logic [30:0]        nq_c;

	logic signed [63:0] plo_s4;
	logic signed [63:0] phi_s4;
	logic [30:0]        nq_s4;

	logic signed [63:0] ts_s5;

	// Advance a stage when it is empty or the next one advances
	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s4 || en_s5 ? (!v_s3 || en_s4) : !v_s3;
	assign in_ready = en_s3;

	// Seconds since epoch
	assign days48 = {{21{in_data.days[26]}}, in_data.days};
	assign secs48 = {{24{in_data.secs[23]}}, in_data.secs};
	assign t_c    = days48 * SECS_PER_DAY + secs48;

	// Remainder of the nanos estimate, at most one divisor too large
	assign ndiv  = nano_div(dig);
	assign qd_c  = in_data.nq_est * ndiv;
	assign rem_c = {1'b0, in_data.nanos} - qd_c[30:0];

	// Scale by 10^dig as two half-width partial products
	assign scale = unit_scale(dig);
	assign plo_c = t_s3 * $signed({1'b0, scale[14:0]});
	assign phi_c = t_s3 * $signed({1'b0, scale[29:15]});
	assign nq_c  = nq_s3 + 31'((rem_s3 >= {1'b0, ndiv}) ? 1 : 0);

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= in_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (en_s3) begin
			t_s3   <= t_c;
			rem_s3 <= rem_c;
			nq_s3  <= in_data.nq_est;
		end
		if (en_s4) begin
			plo_s4 <= plo_c;
			phi_s4 <= phi_c;
			nq_s4  <= nq_c;
		end
		if (en_s5) begin
			ts_s5 <= plo_s4 + (phi_s4 <<< 15) + $signed({33'd0, nq_s4});
		end
	end

	assign out_valid = v_s5;
	assign timestamp = ts_s5;

endmodule

@@ hdl/civil_datetime_to_epoch_core.sv @@
// Top level: civil date/time to epoch timestamp converter with its digit register.
//
// Converts one broken-down Gregorian date and time per item into a signed
// 64-bit count of units since 1970-01-01 00:00:00 UTC. The unit is set by
// the fraction digit register written through cfg_we/cfg_data: 0 seconds,
// 3 ms, 6 us, 9 ns; values above 9 act as 9. Write it only while idle.
//
// Input and output channels use valid/ready; an item moves at a clock edge
// where both are high. The datapath is a five-stage pipeline: two stages
// build the day count and seconds of day, three scale to the unit and add
// the truncated nanoseconds. Throughput is one item per cycle while the
// receiver holds out_ready high.
//
// When the receiver holds out_ready low, the output stage holds its result
// and the stages behind it keep filling empty slots; in_ready drops only
// once every stage is occupied. Reset clears all stage valid bits and sets
// the digit register to 0 (seconds).
module civil_datetime_to_epoch_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] year,
	input  logic [3:0]         month,
	input  logic [4:0]         day,
	input  logic [4:0]         hour,
	input  logic [5:0]         minute,
	input  logic [5:0]         second,
	input  logic [29:0]        nanos,
	input  logic signed [19:0] tz_offset,
	input  logic [1:0]         meridiem,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] timestamp
);
	import cdte_pkg::*;

	logic [3:0] frac_digits_q;
	logic [3:0] dig;
	logic       mid_valid;
	logic       mid_ready;
	cdte_mid_t  mid_data;

	// Hold the fraction digit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_digits_q <= 4'd0;
		end else if (cfg_we) begin
			frac_digits_q <= cfg_data;
		end
	end

	assign dig = sat_digits(frac_digits_q);

	cdte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.year      (year),
		.month     (month),
		.day       (day),
		.hour      (hour),
		.minute    (minute),
		.second    (second),
		.nanos     (nanos),
		.tz_offset (tz_offset),
		.meridiem  (meridiem),
		.dig       (dig),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_data  (mid_data)
	);

	cdte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_data   (mid_data),
		.dig       (dig),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.timestamp (timestamp)
	);

	// An empty output stage lets every stage advance
	a_empty_out_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output stage");

	// A ready receiver never backs up the pipeline
	a_ready_flows: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while receiver is ready");

	// With the receiver ready throughout, an accepted item reaches the output stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		($past(in_valid && in_ready, 5) && $past(arst_n, 5) && $past(arst_n, 4)
			&& $past(arst_n, 3) && $past(arst_n, 2) && $past(arst_n, 1)
			&& $past(out_ready, 4) && $past(out_ready, 3)
			&& $past(out_ready, 2) && $past(out_ready, 1)) |-> out_valid)
		else $error("accepted item did not reach the output in time");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the civil date/time to epoch timestamp converter.
module tb;
	import cdte_pkg::*;

	// Marker code with no meaning of its own; the block treats it as no marker
	localparam logic [1:0] MER_SPARE = 2'd3;
	localparam longint NOON_SECS = 43200;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int ITEMS_PER_SETTING = 88;

	typedef struct {
		logic signed [15:0] year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [5:0]         second;
		logic [29:0]        nanos;
		logic signed [19:0] tz_offset;
		logic [1:0]         meridiem;
	} datetime_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [3:0]         cfg_data;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] year;
	logic [3:0]         month;
	logic [4:0]         day;
	logic [4:0]         hour;
	logic [5:0]         minute;
	logic [5:0]         second;
	logic [29:0]        nanos;
	logic signed [19:0] tz_offset;
	logic [1:0]         meridiem;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [63:0] timestamp;

	datetime_t   bus_item = '{default: '0};
	datetime_t   items_pending[$];
	logic [63:0] stamps_due[$];
	logic [3:0]  unit_digits = 4'd0;
	logic        in_taken = 1'b0;
	logic        steady;
	int          hold_asked;
	int          hold_given = 0;
	int          hold_left = 0;
	int          mismatches = 0;

	assign year      = bus_item.year;
	assign month     = bus_item.month;
	assign day       = bus_item.day;
	assign hour      = bus_item.hour;
	assign minute    = bus_item.minute;
	assign second    = bus_item.second;
	assign nanos     = bus_item.nanos;
	assign tz_offset = bus_item.tz_offset;
	assign meridiem  = bus_item.meridiem;

	civil_datetime_to_epoch_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.year      (year),
		.month     (month),
		.day       (day),
		.hour      (hour),
		.minute    (minute),
		.second    (second),
		.nanos     (nanos),
		.tz_offset (tz_offset),
		.meridiem  (meridiem),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.timestamp (timestamp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Units since epoch for one date/time at the given digit setting, wrapping mod 2^64
	function automatic logic [63:0] epoch_units(datetime_t dt, logic [3:0] digits);
		longint y, m, era, yoe, mp, doy, doe, days, secs, hr;
		logic [63:0] total, scale, per_unit;
		int dig;
		y = longint'(dt.year);
		m = longint'(dt.month);
		hr = longint'(dt.hour);
		// March-based year: January and February belong to the year before
		if (m <= 2)
			y = y - 1;
		era = (y < 0 ? y - 399 : y) / 400;
		yoe = y - era * 400;
		mp = (m <= 2) ? m + 9 : m - 3;
		doy = (153 * mp + 2) / 5 + longint'(dt.day) - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		days = era * 146097 + doe - 719468;
		secs = 3600 * hr + 60 * longint'(dt.minute) + longint'(dt.second)
			- longint'(dt.tz_offset);
		if (dt.meridiem == MER_PM && dt.hour != 5'd12)
			secs = secs + NOON_SECS;
		else if (dt.meridiem == MER_AM && dt.hour == 5'd12)
			secs = secs - NOON_SECS;
		dig = (digits > MAX_DIGITS) ? int'(MAX_DIGITS) : int'(digits);
		scale = 64'd1;
		per_unit = 64'd1;
		repeat (dig) scale = scale * 64'd10;
		repeat (9 - dig) per_unit = per_unit * 64'd10;
		total = days * 86400 + secs;
		total = total * scale + {34'd0, dt.nanos} / per_unit;
		return total;
	endfunction

	function automatic datetime_t make_datetime(int y, int mo, int d, int h, int mi, int s,
			int ns, int tz, logic [1:0] mer);
		datetime_t dt;
		dt.year = 16'(y);
		dt.month = 4'(mo);
		dt.day = 5'(d);
		dt.hour = 5'(h);
		dt.minute = 6'(mi);
		dt.second = 6'(s);
		dt.nanos = 30'(ns);
		dt.tz_offset = 20'(tz);
		dt.meridiem = mer;
		return dt;
	endfunction

	// In-range dates around the present, from -1000 to 3000 or anywhere in the year range; some raw noise
	function automatic datetime_t random_datetime();
		datetime_t dt;
		int pick;
		if ($urandom_range(99) < 15) begin
			dt.year = 16'($urandom);
			dt.month = 4'($urandom);
			dt.day = 5'($urandom);
			dt.hour = 5'($urandom);
			dt.minute = 6'($urandom);
			dt.second = 6'($urandom);
			dt.nanos = 30'($urandom);
			dt.tz_offset = 20'($urandom);
			dt.meridiem = 2'($urandom);
			return dt;
		end
		pick = $urandom_range(99);
		if (pick < 55)
			dt.year = 16'(1900 + $urandom_range(250));
		else if (pick < 75)
			dt.year = 16'(int'($urandom_range(65535)) - 32768);
		else
			dt.year = 16'(int'($urandom_range(4000)) - 1000);
		dt.month = 4'(1 + $urandom_range(11));
		dt.day = 5'(1 + $urandom_range(30));
		dt.meridiem = 2'($urandom_range(2));
		if (dt.meridiem == MER_NONE)
			dt.hour = 5'($urandom_range(23));
		else
			dt.hour = 5'(1 + $urandom_range(11));
		dt.minute = 6'($urandom_range(59));
		dt.second = 6'($urandom_range(61));
		dt.nanos = 30'($urandom_range(999999999));
		if ($urandom_range(1))
			dt.tz_offset = 20'(900 * (int'($urandom_range(112)) - 56));
		else
			dt.tz_offset = 20'(int'($urandom_range(719880)) - 359940);
		return dt;
	endfunction

	// Drive the input channel: hold an item until taken, then load the next or idle
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (items_pending.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
				bus_item <= items_pending.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Drive out_ready: long hold-off on request, else random stalls unless steady
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_asked != hold_given) begin
			hold_given <= hold_given + 1;
			hold_left <= HOLD_OFF_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 27);
		end
	end

	// Track the digit register, predict accepted items, check delivered results
	always @(posedge clk) begin : check_results
		logic [63:0] want;
		if (arst_n) begin
			if (cfg_we)
				unit_digits <= cfg_data;
			if (in_valid && in_ready)
				stamps_due.push_back(epoch_units(bus_item, unit_digits));
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (stamps_due.size() == 0) begin
					mismatches++;
					$display("%0t: timestamp expected none actual %0d", $time, timestamp);
				end else begin
					want = stamps_due.pop_front();
					if (timestamp !== want) begin
						mismatches++;
						$display("%0t: timestamp expected %0d actual %0d", $time,
							$signed(want), timestamp);
					end
				end
			end
		end
	end

	// Wait until every item is taken and every result is back, then let the pipe settle
	task automatic wait_drained();
		while (items_pending.size() != 0 || in_valid || stamps_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_digits(logic [3:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_random(int count);
		repeat (count) items_pending.push_back(random_datetime());
	endtask

	initial begin
		logic [3:0] settings[16];
		settings = '{4'd9, 4'd3, 4'd15, 4'd6, 4'd0, 4'd12, 4'd1, 4'd10,
			4'd2, 4'd4, 4'd5, 4'd7, 4'd8, 4'd11, 4'd13, 4'd14};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 4'd0;
		steady = 1'b0;
		hold_asked = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items at the reset setting (whole seconds)
		items_pending.push_back(make_datetime(1970, 1, 1, 0, 0, 0, 0, 0, MER_NONE));
		items_pending.push_back(make_datetime(1969, 12, 31, 23, 59, 59, 999999999, 0,
			MER_NONE));
		items_pending.push_back(make_datetime(2000, 2, 29, 12, 30, 45, 123456789, 3600,
			MER_NONE));
		items_pending.push_back(make_datetime(-32768, 1, 1, 0, 0, 0, 0, 0, MER_NONE));
		items_pending.push_back(make_datetime(32767, 12, 31, 23, 59, 61, 999999999, 0,
			MER_NONE));
		items_pending.push_back(make_datetime(0, 3, 1, 0, 0, 0, 0, 0, MER_NONE));
		items_pending.push_back(make_datetime(-1, 2, 28, 6, 0, 0, 0, 0, MER_NONE));
		items_pending.push_back(make_datetime(1900, 3, 1, 0, 0, 0, 0, 0, MER_NONE));
		// Month zero, months past December, day zero
		items_pending.push_back(make_datetime(2024, 0, 15, 8, 0, 0, 0, 0, MER_NONE));
		items_pending.push_back(make_datetime(2024, 13, 1, 0, 0, 0, 0, 0, MER_NONE));
		items_pending.push_back(make_datetime(2024, 14, 29, 0, 0, 0, 0, 0, MER_NONE));
		items_pending.push_back(make_datetime(2024, 15, 31, 0, 0, 0, 0, 0, MER_NONE));
		items_pending.push_back(make_datetime(2023, 5, 0, 0, 0, 0, 0, 0, MER_NONE));
		// Time fields at their widest, nanos past one second, zone offset extremes
		items_pending.push_back(make_datetime(2023, 5, 31, 31, 63, 63, 0, 0, MER_NONE));
		items_pending.push_back(make_datetime(2023, 6, 1, 0, 0, 0, 32'h3FFFFFFF, 0,
			MER_NONE));
		items_pending.push_back(make_datetime(1999, 7, 4, 0, 0, 0, 0, -524288, MER_NONE));
		items_pending.push_back(make_datetime(1999, 7, 4, 0, 0, 0, 0, 524287, MER_NONE));
		// Meridiem handling, including the spare code and out-of-range hours
		items_pending.push_back(make_datetime(2010, 10, 10, 12, 15, 0, 0, 0, MER_AM));
		items_pending.push_back(make_datetime(2010, 10, 10, 12, 15, 0, 0, 0, MER_PM));
		items_pending.push_back(make_datetime(2010, 10, 10, 5, 15, 0, 0, 0, MER_PM));
		items_pending.push_back(make_datetime(2010, 10, 10, 5, 15, 0, 0, 0, MER_AM));
		items_pending.push_back(make_datetime(2010, 10, 10, 7, 15, 0, 0, 0, MER_SPARE));
		items_pending.push_back(make_datetime(2010, 10, 10, 0, 0, 0, 0, 0, MER_PM));
		items_pending.push_back(make_datetime(2010, 10, 10, 31, 0, 0, 0, 0, MER_PM));
		wait_drained();

		// Random items under every digit setting
		foreach (settings[i]) begin
			write_digits(settings[i]);
			steady = (settings[i] == 4'd1);
			queue_random(ITEMS_PER_SETTING);
			// Stall the receiver long enough for the pipe to fill and push back
			if (settings[i] == 4'd6 || settings[i] == 4'd5)
				hold_asked = hold_asked + 1;
			wait_drained();
		end
		steady = 1'b0;

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Abort a hung run
	initial begin
		#3000000;
		$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/cdte_pkg.sv
hdl/cdte_front.sv
hdl/cdte_back.sv
hdl/civil_datetime_to_epoch_core.sv
bench/tb.sv
